FILE: rtl/core/i2a_pkg.sv
// i2a_pkg: word types, mode codes and character constants for the
// integer to ascii converter. no dependencies.
package i2a_pkg;

   localparam int FIELD_WIDTH = 64;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [FIELD_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] ascii_char;
      logic       last_char;
   } rsp_type;

   // mode codes; the unused code behaves as unsigned decimal
   localparam logic [1:0] CMD_UDEC = 2'd0;
   localparam logic [1:0] CMD_SDEC = 2'd1;
   localparam logic [1:0] CMD_HEX  = 2'd2;

   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_A     = 8'h61;
   localparam logic [7:0] CHR_MINUS = 8'h2d;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHR_ZERO + {4'b0000, d};
      end else begin
         c = CHR_A - 8'd10 + {4'b0000, d};
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/i2a_dabble.sv
// i2a_dabble: one shift-and-add-3 step of binary to bcd conversion.
// every digit of at least 5 gets 3 added, then the vector shifts in one bit.
// depends on nothing.
module i2a_dabble #(
   parameter int NUM_DIGITS = 20
) (
   input  logic [NUM_DIGITS*4-1:0] digits,
   input  logic                    bit_in,
   output logic [NUM_DIGITS*4-1:0] digits_next
);

   logic [NUM_DIGITS*4-1:0] adjusted;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digits[i*4 +: 4] >= 4'd5) begin
            adjusted[i*4 +: 4] = digits[i*4 +: 4] + 4'd3;
         end else begin
            adjusted[i*4 +: 4] = digits[i*4 +: 4];
         end
      end
   end

   assign digits_next = {adjusted[NUM_DIGITS*4-2:0], bit_in};

endmodule

FILE: rtl/core/integer_to_ascii_digits.sv
// integer_to_ascii_digits: top level of the binary to ascii text converter.
// uses i2a_pkg for word types and constants, i2a_dabble for the bcd step.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  req_type: cmd, value
//   rsp      out        rsp_valid/rsp_stall  rsp_type: ascii_char, last_char
//
// one word in is loaded, then in decimal modes each value bit is shifted through the
// shared add-3/shift unit (hex skips this), then leading zeros are dropped, then the
// characters are sent one per rsp word, a '-' first for a negative signed value.
// reset clears the sequencer and the output valid; req_stall is high while busy.
// a stalled rsp holds its character and the sequencer waits for it.
module integer_to_ascii_digits
   import i2a_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
   localparam int BIT_W      = $clog2(VALUE_WIDTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [BIT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_word_ff, rsp_word_in;

   logic [VALUE_WIDTH-1:0] raw_value;
   logic                   raw_neg;
   logic [BCD_W-1:0]       bcd_step;
   logic [3:0]             top_digit;
   logic                   slot_free;

   assign raw_value = req_data.value[VALUE_WIDTH-1:0];
   assign raw_neg   = (req_data.cmd == CMD_SDEC) && raw_value[VALUE_WIDTH-1];
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   i2a_dabble #(
      .NUM_DIGITS(NUM_DIGITS)
   ) u_dabble (
      .digits      (bcd_ff),
      .bit_in      (mag_ff[VALUE_WIDTH-1]),
      .digits_next (bcd_step)
   );

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in     = raw_neg;
               mag_in     = raw_neg ? (~raw_value + 1'b1) : raw_value;
               cnt_in     = CNT_W'(NUM_DIGITS);
               bit_cnt_in = BIT_W'(VALUE_WIDTH);
               if (req_data.cmd == CMD_HEX) begin
                  // hex digits are the nibbles themselves
                  bcd_in   = {{(BCD_W-VALUE_WIDTH){1'b0}}, raw_value};
                  state_in = ST_SKIP;
               end else begin
                  bcd_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            bcd_in     = bcd_step;
            mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BIT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if (top_digit == 4'd0 && cnt_ff != CNT_W'(1)) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'b0000};
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_word_in.ascii_char = CHR_MINUS;
                  rsp_word_in.last_char  = 1'b0;
                  neg_in                 = 1'b0;
               end else begin
                  rsp_word_in.ascii_char = digit_char(top_digit);
                  rsp_word_in.last_char  = (cnt_ff == CNT_W'(1));
                  bcd_in                 = {bcd_ff[BCD_W-5:0], 4'b0000};
                  cnt_in                 = cnt_ff - 1'b1;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         bit_cnt_ff   <= '0;
         mag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         mag_ff       <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff      <= bcd_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

FILE: tb/sv/i2a_text_checker.sv
// i2a_text_checker: watches both channels of integer_to_ascii_digits, predicts
// the text of every accepted value and compares each character word.
// depends on i2a_pkg for the word types, mode codes and character constants.
`timescale 1ns / 100ps

module i2a_text_checker
   import i2a_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_chars,
   output int      checked_chars
);

   rsp_type expected_chars [$];
   rsp_type want;
   int      mismatches;
   int      chars_seen;

   task automatic report_mismatch(input string what);
      // keep the log short when the block is badly broken
      if (mismatches < 200) begin
         $display("%0t checker: %s", $time, what);
      end
      mismatches++;
   endtask

   // queue every character the block should send for one input word
   function automatic void predict_text(input req_type w);
      logic [63:0] magnitude;
      logic [63:0] base;
      logic [63:0] rem;
      logic [3:0]  digits [$];
      logic        is_negative;
      rsp_type     c;
      int          i;
      is_negative = (w.cmd == CMD_SDEC) && w.value[63];
      magnitude = is_negative ? (~w.value + 64'd1) : w.value;
      base = (w.cmd == CMD_HEX) ? 64'd16 : 64'd10;
      do begin
         rem = magnitude % base;
         digits.push_back(rem[3:0]);
         magnitude = magnitude / base;
      end while (magnitude != 64'd0);
      if (is_negative) begin
         c.ascii_char = CHR_MINUS;
         c.last_char  = 1'b0;
         expected_chars.push_back(c);
      end
      for (i = digits.size() - 1; i >= 0; i--) begin
         if (digits[i] < 4'd10) begin
            c.ascii_char = CHR_ZERO + {4'b0000, digits[i]};
         end else begin
            c.ascii_char = CHR_A + {4'b0000, digits[i]} - 8'd10;
         end
         c.last_char = (i == 0);
         expected_chars.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         mismatches = 0;
         chars_seen = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_text(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected word char %h last %b",
                                         rsp_data.ascii_char, rsp_data.last_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.ascii_char !== want.ascii_char) begin
                  report_mismatch($sformatf("word %0d: char %h, want %h", chars_seen,
                                            rsp_data.ascii_char, want.ascii_char));
               end
               if (rsp_data.last_char !== want.last_char) begin
                  report_mismatch($sformatf("word %0d: last %b, want %b", chars_seen,
                                            rsp_data.last_char, want.last_char));
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_chars <= expected_chars.size();
      checked_chars <= chars_seen;
   end

endmodule

FILE: tb/sv/tb.sv
// tb: top of the integer_to_ascii_digits testbench; drives edge values, then values in
// three idle mixes, randomizes rsp_stall and gives the verdict from i2a_text_checker.
// depends on i2a_pkg, integer_to_ascii_digits and i2a_text_checker.
`timescale 1ns / 100ps

module tb;
   import i2a_pkg::*;

   // the fourth mode code has no meaning of its own
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] TOP_BIT   = 64'h8000_0000_0000_0000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int pending_chars;
   int checked_chars;
   int send_idle_pct;
   int recv_idle_pct;
   int sent_words;

   integer_to_ascii_digits dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   i2a_text_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_chars (pending_chars),
      .checked_chars (checked_chars)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // returns at the edge where the word was taken
   task automatic send_word(input logic [1:0] c, input logic [63:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data.cmd   <= c;
      req_data.value <= v;
      do @(posedge clock); while (req_stall);
      sent_words++;
   endtask

   task automatic run_random_phase(input int words, input int send_pct, input int recv_pct);
      logic [63:0] v;
      logic [63:0] step;
      logic [1:0]  c;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (words) begin
         v = {$urandom, $urandom};
         step = 64'd1;
         case ($urandom_range(5))
            0: v = v >> $urandom_range(63);
            1: v = ~(v >> $urandom_range(63));
            2: begin
               // around a power of ten, either sign
               repeat ($urandom_range(19)) step = step * 64'd10;
               v = step + $urandom_range(2) - 64'd1;
               if ($urandom_range(1) == 1) begin
                  v = -v;
               end
            end
            3: v = (64'd1 << (4 * $urandom_range(15))) + $urandom_range(2) - 64'd1;
            default: ;
         endcase
         case ($urandom_range(9))
            0:       c = CMD_UNUSED;
            1, 2, 3: c = CMD_HEX;
            4, 5, 6: c = CMD_SDEC;
            default: c = CMD_UDEC;
         endcase
         send_word(c, v);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 26;
      recv_idle_pct = 59;
      sent_words    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero in every mode, widths and sign edges, every hex digit
      send_word(CMD_UDEC, 64'd0);
      send_word(CMD_SDEC, 64'd0);
      send_word(CMD_HEX, 64'd0);
      send_word(CMD_UNUSED, 64'd0);
      send_word(CMD_UDEC, ALL_ONES);
      send_word(CMD_SDEC, ALL_ONES);
      send_word(CMD_HEX, ALL_ONES);
      send_word(CMD_UNUSED, ALL_ONES);
      send_word(CMD_SDEC, TOP_BIT);
      send_word(CMD_UDEC, TOP_BIT);
      send_word(CMD_HEX, TOP_BIT);
      send_word(CMD_UNUSED, TOP_BIT);
      send_word(CMD_SDEC, ~TOP_BIT);
      send_word(CMD_SDEC, 64'd1);
      send_word(CMD_SDEC, 64'hffff_ffff_ffff_fff6);
      send_word(CMD_UDEC, 64'd9);
      send_word(CMD_UDEC, 64'd10);
      send_word(CMD_UDEC, 64'd10000000000000000000);
      send_word(CMD_HEX, 64'd15);
      send_word(CMD_HEX, 64'd16);
      send_word(CMD_HEX, 64'h0123_4567_89ab_cdef);
      send_word(CMD_HEX, 64'hfedc_ba98_7654_3210);

      run_random_phase(100, 26, 59);
      run_random_phase(100, 59, 26);
      run_random_phase(100, 0, 0);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_chars != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("tb: %0d values converted over three idle mixes, %0d characters compared",
               sent_words, checked_chars);
      $display("tb: %0d mismatches, %0d characters still outstanding",
               error_count, pending_chars);
      if (error_count == 0 && pending_chars == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: timed out waiting for the converter");
      $display("tb: done, errors");
      $finish;
   end

endmodule

FILE: integer_to_ascii_digits.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_dabble.sv
rtl/core/integer_to_ascii_digits.sv
tb/sv/i2a_text_checker.sv
tb/sv/tb.sv
